// File: rtl/cleb_pkg.sv
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared types, constants and pointer helpers for the console line edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

	// ring geometry
	localparam int RING_DEPTH = 128;
	localparam int PTR_SPAN   = 2 * RING_DEPTH;
	localparam int PTR_W      = $clog2(PTR_SPAN);
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CMP_W      = (PTR_W > 8) ? PTR_W : 8;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// key codes
	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_DEL    = 8'h7f;
	localparam logic [7:0] KEY_CR     = 8'h0d;
	localparam logic [7:0] KEY_LF     = 8'h0a;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CTRL_C = 8'h03;
	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] ERASE_MAX  = 8'hff;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_IGNORED = 3'd1,
		ST_FULL    = 3'd2,
		ST_INTR    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	// result of one word, read byte excluded
	typedef struct packed {
		status_t    status;
		logic       echo_valid;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       line_committed;
		logic       wake_all;
		logic       pop;
	} ctrl_res_t;

	// ring memory request
	typedef struct packed {
		logic       wr_en;
		slot_t      wr_addr;
		logic [7:0] wr_data;
		logic       rd_en;
		slot_t      rd_addr;
	} mem_req_t;

	// pointer arithmetic modulo twice the depth
	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(PTR_SPAN - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		return (p == '0) ? ptr_t'(PTR_SPAN - 1) : p - ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_dist(input ptr_t hi, input ptr_t lo);
		logic [PTR_W:0] d;
		d = {1'b0, hi} - {1'b0, lo};
		if (d[PTR_W])
			d = d + (PTR_W+1)'(PTR_SPAN);
		return d[PTR_W-1:0];
	endfunction

	function automatic slot_t slot_of(input ptr_t p);
		logic [PTR_W-1:0] s;
		s = (p >= ptr_t'(RING_DEPTH)) ? p - ptr_t'(RING_DEPTH) : p;
		return s[SLOT_W-1:0];
	endfunction

endpackage

// File: rtl/cleb_ram.sv
// ----------------------------------------------------------------------------
// cleb_ram
// Single write port, single read port synchronous ram, registered read data.
// ----------------------------------------------------------------------------
module cleb_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/cleb_ctrl.sv
// ----------------------------------------------------------------------------
// cleb_ctrl
// Pointer registers and key decode; issues ring writes and reads per word.
// ----------------------------------------------------------------------------
module cleb_ctrl import cleb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       cmd,
	input  logic [7:0] rx_char,
	output ctrl_res_t  res,
	output mem_req_t   mem_req
);

	ptr_t read_ptr_q, commit_ptr_q, edit_ptr_q;
	ptr_t read_ptr_n, commit_ptr_n, edit_ptr_n;
	ptr_t dist_er, dist_ec;
	logic full;
	logic [7:0] store_char;
	logic [CMP_W:0] edit_ext, edit_m255;
	logic wr_req, rd_req;

	assign dist_er  = ptr_dist(edit_ptr_q, read_ptr_q);
	assign dist_ec  = ptr_dist(edit_ptr_q, commit_ptr_q);
	assign full     = dist_er >= ptr_t'(RING_DEPTH);

	// edit pointer moved back by the largest ctrl-u erase
	assign edit_ext  = (CMP_W+1)'(edit_ptr_q);
	assign edit_m255 = (edit_ext >= (CMP_W+1)'(ERASE_MAX)) ?
		edit_ext - (CMP_W+1)'(ERASE_MAX) :
		edit_ext + (CMP_W+1)'(PTR_SPAN) - (CMP_W+1)'(ERASE_MAX);

	// cr and ctrl-d are stored as newline
	assign store_char = (rx_char == KEY_CR || rx_char == KEY_CTRL_D) ? KEY_LF : rx_char;

	// key decode and next pointers
	always_comb begin
		res          = '0;
		res.status   = ST_OK;
		read_ptr_n   = read_ptr_q;
		commit_ptr_n = commit_ptr_q;
		edit_ptr_n   = edit_ptr_q;
		wr_req       = 1'b0;
		rd_req       = 1'b0;
		if (cmd) begin
			if (read_ptr_q == commit_ptr_q) begin
				res.status = ST_EMPTY;
			end else begin
				rd_req     = 1'b1;
				res.pop    = 1'b1;
				read_ptr_n = ptr_inc(read_ptr_q);
			end
		end else if (rx_char == KEY_NUL || rx_char[7]) begin
			res.status = ST_IGNORED;
		end else if (rx_char == KEY_BS || rx_char == KEY_DEL) begin
			if (edit_ptr_q != commit_ptr_q) begin
				edit_ptr_n      = ptr_dec(edit_ptr_q);
				res.erase_count = 8'd1;
			end
		end else if (rx_char == KEY_CTRL_U) begin
			if ((CMP_W)'(dist_ec) > (CMP_W)'(ERASE_MAX)) begin
				res.erase_count = ERASE_MAX;
				edit_ptr_n      = edit_m255[PTR_W-1:0];
			end else begin
				res.erase_count = 8'((CMP_W)'(dist_ec));
				edit_ptr_n      = commit_ptr_q;
			end
		end else if (rx_char == KEY_CTRL_C) begin
			res.status = ST_INTR;
		end else if (full) begin
			res.status = ST_FULL;
		end else begin
			wr_req         = 1'b1;
			edit_ptr_n     = ptr_inc(edit_ptr_q);
			res.echo_valid = 1'b1;
			res.echo_char  = store_char;
			res.wake_all   = (rx_char == KEY_LF || rx_char == KEY_CTRL_D);
			// commit on newline or when the ring just filled up
			if (store_char == KEY_LF || dist_er == ptr_t'(RING_DEPTH - 1)) begin
				commit_ptr_n       = edit_ptr_n;
				res.line_committed = 1'b1;
			end
		end
	end

	// ring access
	always_comb begin
		mem_req.wr_en   = accept && wr_req;
		mem_req.wr_addr = slot_of(edit_ptr_q);
		mem_req.wr_data = store_char;
		mem_req.rd_en   = accept && rd_req;
		mem_req.rd_addr = slot_of(read_ptr_q);
	end

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_ptr_q   <= '0;
			commit_ptr_q <= '0;
			edit_ptr_q   <= '0;
		end else if (accept) begin
			read_ptr_q   <= read_ptr_n;
			commit_ptr_q <= commit_ptr_n;
			edit_ptr_q   <= edit_ptr_n;
		end
	end

endmodule

// File: rtl/console_line_edit_buffer.sv
// An accepted word waits in stage 1 with its ring read, then moves to the output register.
// Throughput: one word per cycle while out_stall is low; pointers update at accept and
// the ring read data lands in the ram's read register at that same edge.
// Reset: arst_n clears the three ring pointers and the stage valid flags; the ring
// contents stay undefined until written.
// ----------------------------------------------------------------------------
// console_line_edit_buffer
// Canonical-mode console input ring with line editing and committed-byte reads.
// ----------------------------------------------------------------------------
module console_line_edit_buffer import cleb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic       echo_valid,
	output logic [7:0] echo_char,
	output logic [7:0] erase_count,
	output logic       line_committed,
	output logic       wake_all,
	output logic       read_valid,
	output logic [7:0] read_char,
	output logic       read_line_end
);

	logic       accept;
	logic       out_free, s1_adv;
	logic       s1_valid_q;
	ctrl_res_t  res, res_s1;
	mem_req_t   mem_req;
	logic [7:0] rd_data;
	logic [7:0] rd_char;
	logic       out_valid_q;
	ctrl_res_t  out_res_q;
	logic [7:0] out_rchar_q;

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign accept   = in_valid && !in_stall;

	cleb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.rx_char (rx_char),
		.res     (res),
		.mem_req (mem_req)
	);

	cleb_ram #(.DEPTH(RING_DEPTH), .WIDTH(8)) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	// stage 1 valid, waits for the ring read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= res;
	end

	assign rd_char = res_s1.pop ? rd_data : 8'h00;

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_res_q   <= res_s1;
			out_rchar_q <= rd_char;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign echo_valid     = out_res_q.echo_valid;
	assign echo_char      = out_res_q.echo_char;
	assign erase_count    = out_res_q.erase_count;
	assign line_committed = out_res_q.line_committed;
	assign wake_all       = out_res_q.wake_all;
	assign read_valid     = out_res_q.pop;
	assign read_char      = out_rchar_q;
	assign read_line_end  = out_res_q.pop && (out_rchar_q == KEY_LF);

endmodule

// File: rtl/cleb_checker.sv
// ----------------------------------------------------------------------------
// cleb_checker
// Port-level checks on the console line edit buffer's result words.
// ----------------------------------------------------------------------------
module cleb_checker import cleb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic       echo_valid,
	input logic [7:0] echo_char,
	input logic [7:0] erase_count,
	input logic       line_committed,
	input logic       wake_all,
	input logic       read_valid,
	input logic [7:0] read_char,
	input logic       read_line_end
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_char))
		else $error("result word changed while stalled");

	// a woken line is always a newline commit
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wake_all |-> line_committed && echo_valid && echo_char == KEY_LF)
		else $error("wake without newline commit");

	// a commit only follows a stored, echoed byte
	a_commit_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_committed |-> echo_valid && status == ST_OK && erase_count == 8'd0)
		else $error("commit without stored byte");

	// a popped byte comes with ok status and never with an echo
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> status == ST_OK && !echo_valid && !line_committed)
		else $error("pop with wrong status or echo");

	// no popped byte means empty read fields
	a_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_char == 8'h00 && !read_line_end)
		else $error("read fields set without a pop");

endmodule

bind console_line_edit_buffer cleb_checker u_cleb_checker (.*);
